// ===== src/btk_pkg.sv =====
// Package for the bucketed top-K sorted store: sizes, row and slot types,
// action codes and the move width helpers. Depends on nothing.
package btk_pkg;

  localparam int BUCKETS   = 256;
  localparam int KEEP      = 8;
  localparam int MOVE_BITS = 16;

  // Only bucket numbers that fit the 8-bit bucket field can be addressed.
  localparam int ROWS    = (BUCKETS < 256) ? BUCKETS : 256;
  localparam int IDX_W   = $clog2(ROWS);
  localparam int COUNT_W = $clog2(KEEP + 1);
  localparam int SLOT_W  = $clog2(KEEP);

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_REWIND = 2'd2,
    ACT_READ   = 2'd3
  } act_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    logic [MOVE_BITS-1:0] move;
    logic signed [15:0]   score;
  } slot_t;

  typedef struct packed {
    logic [COUNT_W-1:0]   count;
    slot_t [KEEP-1:0]     slot;
  } row_t;

  // Result of one row update, handed from the update logic to the control.
  typedef struct packed {
    logic        ok;
    logic [15:0] move_out;
    logic        wr_en;
    row_t        row;
  } upd_t;

  // Keep the low MOVE_BITS bits of the 16-bit move field.
  function automatic logic [MOVE_BITS-1:0] to_move(logic [15:0] v);
    logic [31:0] t;
    t = {16'd0, v};
    return t[MOVE_BITS-1:0];
  endfunction

  // Bring a stored move back to the 16-bit output field.
  function automatic logic [15:0] from_move(logic [MOVE_BITS-1:0] m);
    logic [31:0] t;
    t = 32'(m);
    return t[15:0];
  endfunction

endpackage

// ===== src/btk_if.sv =====
// Valid/ready channel interfaces for the command and result streams.
// Depends on nothing.
interface btk_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic [7:0]         bucket;
  logic [15:0]        move_in;
  logic signed [15:0] score_in;

  modport source (output valid, action, bucket, move_in, score_in, input ready);
  modport sink   (input valid, action, bucket, move_in, score_in, output ready);
endinterface

interface btk_out_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic [15:0] move_out;

  modport source (output valid, ok, move_out, input ready);
  modport sink   (input valid, ok, move_out, output ready);
endinterface

// ===== src/btk_row_ram.sv =====
// Row memory of the store: one row per bucket holding the count and all slots.
// Depends on btk_pkg.
module btk_row_ram
  import btk_pkg::*;
(
  input  logic             clk,
  input  logic             we,
  input  logic [IDX_W-1:0] waddr,
  input  row_t             wdata,
  input  logic             re,
  input  logic [IDX_W-1:0] raddr,
  output row_t             rdata
);

  row_t mem [ROWS];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/btk_row_update.sv =====
// Row update logic: parallel compare-and-shift insert and slot read.
// Depends on btk_pkg.
module btk_row_update
  import btk_pkg::*;
(
  input  row_t               row,
  input  act_t               action,
  input  logic               in_range,
  input  logic [MOVE_BITS-1:0] move,
  input  logic signed [15:0] score,
  input  logic [COUNT_W-1:0] rp,
  output upd_t               upd
);

  localparam logic [COUNT_W-1:0] KEEP_C = COUNT_W'(KEEP);

  logic               full;
  logic               ins_ok;
  logic [COUNT_W-1:0] n_eff;
  logic [KEEP-1:0]    keep_old;
  logic               rd_ok;
  row_t               new_row;

  // A full bucket drops its worst slot, but only for a strictly better score.
  assign full   = (row.count >= KEEP_C);
  assign ins_ok = in_range && (!full || (score < row.slot[KEEP-1].score));
  assign n_eff  = full ? COUNT_W'(KEEP - 1) : row.count;

  // Slots are sorted, so a slot keeps its place when its score does not exceed the new one.
  always_comb begin
    for (int i = 0; i < KEEP; i++) begin
      keep_old[i] = (COUNT_W'(i) < n_eff) && !(score < row.slot[i].score);
    end
  end

  // Each slot keeps, takes the new entry, or takes its lower neighbor.
  always_comb begin
    new_row.count = n_eff + COUNT_W'(1);
    for (int i = 0; i < KEEP; i++) begin
      if (keep_old[i]) begin
        new_row.slot[i] = row.slot[i];
      end else if (i == 0) begin
        new_row.slot[i] = '{move: move, score: score};
      end else if (keep_old[i-1]) begin
        new_row.slot[i] = '{move: move, score: score};
      end else begin
        new_row.slot[i] = row.slot[i-1];
      end
    end
  end

  assign rd_ok = in_range && (rp < row.count);

  // Result and write-back request per action.
  always_comb begin
    upd.ok       = 1'b1;
    upd.move_out = 16'd0;
    upd.wr_en    = 1'b0;
    upd.row      = new_row;
    case (action)
      ACT_INSERT: begin
        upd.ok    = ins_ok;
        upd.wr_en = ins_ok;
      end
      ACT_READ: begin
        upd.ok = rd_ok;
        if (rd_ok) begin
          upd.move_out = from_move(row.slot[rp[SLOT_W-1:0]].move);
        end
      end
      default: begin
        upd.ok = 1'b1;
      end
    endcase
  end

endmodule

// ===== src/bucketed_top_k_sorted_store_unit.sv =====
// Top level of the bucketed top-K sorted store: control, bucket valid flags,
// read pointer and result register. Depends on btk_pkg, btk_if, btk_row_ram, btk_row_update.
//
//  channel | direction | fields
//  --------+-----------+------------------------------------
//  in_ch   | sink      | action, bucket, move_in, score_in
//  out_ch  | source    | ok, move_out
//
// Every item is handled in two steps: the row read from the row memory, then
// the update and the write-back of that row.
// A result waits in the output register; the next item is taken meanwhile, and
// its update cycle stalls only while the previous result has not been transferred.
// Reset and clear both act at once on the per-bucket valid flags; no clearing pass.
module bucketed_top_k_sorted_store_unit
  import btk_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  btk_in_if.sink        in_ch,
  btk_out_if.source     out_ch
);

  state_t               state;
  state_t               state_next;
  act_t                 action;
  logic [7:0]           bucket;
  logic [MOVE_BITS-1:0] move;
  logic signed [15:0]   score;
  logic [COUNT_W-1:0]   rp;
  logic [ROWS-1:0]      valid;
  logic                 out_valid;
  logic                 out_ok;
  logic [15:0]          out_move;

  logic                 in_fire;
  logic                 finish;
  logic                 can_out;
  logic [IDX_W-1:0]     idx;
  logic                 in_range;
  row_t                 ram_rdata;
  row_t                 row_eff;
  upd_t                 upd;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign can_out  = !out_valid || out_ch.ready;
  assign idx      = bucket[IDX_W-1:0];
  assign in_range = (32'(bucket) < 32'(BUCKETS));

  // Next state and handshake outputs.
  always_comb begin
    state_next  = state;
    in_ch.ready = 1'b0;
    finish      = 1'b0;
    case (state)
      S_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (can_out) begin
          finish     = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Capture the item on transfer.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      action <= act_t'(in_ch.action);
      bucket <= in_ch.bucket;
      move   <= to_move(in_ch.move_in);
      score  <= in_ch.score_in;
    end
  end

  btk_row_ram u_ram (
    .clk   (clk),
    .we    (finish && upd.wr_en),
    .waddr (idx),
    .wdata (upd.row),
    .re    (in_fire),
    .raddr (in_ch.bucket[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  // A bucket never written since the last clear reads as empty.
  always_comb begin
    row_eff = ram_rdata;
    if (!valid[idx]) begin
      row_eff.count = '0;
    end
  end

  btk_row_update u_upd (
    .row      (row_eff),
    .action   (action),
    .in_range (in_range),
    .move     (move),
    .score    (score),
    .rp       (rp),
    .upd      (upd)
  );

  // Valid flags and the shared read pointer.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      rp    <= '0;
    end else if (finish) begin
      case (action)
        ACT_CLEAR: begin
          valid <= '0;
          rp    <= '0;
        end
        ACT_INSERT: begin
          if (upd.wr_en) begin
            valid[idx] <= 1'b1;
          end
        end
        ACT_REWIND: begin
          rp <= '0;
        end
        ACT_READ: begin
          if (upd.ok) begin
            rp <= rp + COUNT_W'(1);
          end
        end
        default: begin
          rp <= rp;
        end
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_ok   <= upd.ok;
      out_move <= upd.move_out;
    end
  end

  assign out_ch.valid    = out_valid;
  assign out_ch.ok       = out_ok;
  assign out_ch.move_out = out_move;

`ifndef SYNTHESIS
  // An accepted item always goes to its update cycle.
  a_fire_exec: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> (state == S_EXEC))
    else $error("accepted item did not enter the update cycle");

  // The row memory is written only in a finishing update cycle.
  a_write_exec: assert property (@(posedge clk) disable iff (rst)
    (upd.wr_en && finish) |-> (state == S_EXEC) && (action == ACT_INSERT))
    else $error("row write outside an insert update");

  // The read pointer never passes the bucket size.
  a_rp_range: assert property (@(posedge clk) disable iff (rst)
    rp <= COUNT_W'(KEEP))
    else $error("read pointer beyond bucket size");

  // A clear leaves every bucket empty and the pointer at zero.
  a_clear: assert property (@(posedge clk) disable iff (rst)
    (finish && (action == ACT_CLEAR)) |=> (valid == '0) && (rp == '0))
    else $error("clear did not empty the store");

  // A nonzero move is only reported with a found flag.
  a_move_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_move != 16'd0)) |-> out_ok)
    else $error("move reported without found flag");
`endif

endmodule

// ===== tb/sv/btk_store_checker.sv =====
`timescale 1ns / 100ps
// Passive checker for the bucketed top-K sorted store: predicts every result
// from the command transfers and compares it with the result transfers.
// Depends on btk_pkg and the channel interfaces in btk_if.
module btk_store_checker
  import btk_pkg::*;
(
  input  logic clk,
  input  logic rst,
  btk_in_if    in_ch,
  btk_out_if   out_ch,
  output int   fail_count,
  output int   pending
);

  typedef struct packed {
    logic        ok;
    logic [15:0] move;
  } answer_t;

  localparam int PRINT_CAP = 60;

  // Shadow copy of the store.
  logic [MOVE_BITS-1:0] slot_move  [BUCKETS][KEEP];
  logic signed [15:0]   slot_score [BUCKETS][KEEP];
  int                   fill       [BUCKETS];
  int                   read_pos;

  answer_t answer_q[$];

  initial begin
    fail_count = 0;
    pending    = 0;
    read_pos   = 0;
    foreach (fill[i]) fill[i] = 0;
  end

  // Sorted insert after equal scores; a full bucket drops its worst entry
  // only for a strictly better score.
  function automatic logic place_entry(int b, logic [MOVE_BITS-1:0] mv,
                                       logic signed [15:0] sc);
    int n;
    int pos;
    bit found;
    n = fill[b];
    if (n >= KEEP) begin
      if (!(sc < slot_score[b][KEEP-1])) return 1'b0;
      n = KEEP - 1;
    end
    pos   = n;
    found = 1'b0;
    for (int i = 0; i < n; i++) begin
      if (!found && sc < slot_score[b][i]) begin
        pos   = i;
        found = 1'b1;
      end
    end
    for (int i = n; i > pos; i--) begin
      slot_move[b][i]  = slot_move[b][i-1];
      slot_score[b][i] = slot_score[b][i-1];
    end
    slot_move[b][pos]  = mv;
    slot_score[b][pos] = sc;
    fill[b]            = n + 1;
    return 1'b1;
  endfunction

  // Apply one command to the shadow store and return the answer it gives.
  function automatic answer_t predict_answer(act_t a, logic [7:0] bucket,
                                             logic [15:0] move_in,
                                             logic signed [15:0] score_in);
    answer_t r;
    int b;
    b      = int'(bucket);
    r.ok   = 1'b0;
    r.move = 16'd0;
    case (a)
      ACT_CLEAR: begin
        foreach (fill[i]) fill[i] = 0;
        read_pos = 0;
        r.ok     = 1'b1;
      end
      ACT_INSERT: begin
        if (b < BUCKETS)
          r.ok = place_entry(b, move_in[MOVE_BITS-1:0], score_in);
      end
      ACT_REWIND: begin
        read_pos = 0;
        r.ok     = 1'b1;
      end
      default: begin
        if (b < BUCKETS && read_pos < fill[b] && read_pos < KEEP) begin
          r.move   = 16'(slot_move[b][read_pos]);
          read_pos = read_pos + 1;
          r.ok     = 1'b1;
        end
      end
    endcase
    return r;
  endfunction

  // Sample both channels at the clock edge. Results are checked before the
  // command of the same edge is predicted, since no result can come that fast.
  always @(posedge clk) begin
    answer_t want;
    if (rst) begin
      foreach (fill[i]) fill[i] = 0;
      read_pos = 0;
      answer_q.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (answer_q.size() == 0) begin
          fail_count++;
          if (fail_count <= PRINT_CAP)
            $display("%0t: result with nothing expected: ok %0b move %h",
                     $time, out_ch.ok, out_ch.move_out);
        end else begin
          want = answer_q.pop_front();
          if (out_ch.ok !== want.ok) begin
            fail_count++;
            if (fail_count <= PRINT_CAP)
              $display("%0t: ok mismatch: expected %0b actual %0b",
                       $time, want.ok, out_ch.ok);
          end
          if (out_ch.move_out !== want.move) begin
            fail_count++;
            if (fail_count <= PRINT_CAP)
              $display("%0t: move_out mismatch: expected %h actual %h",
                       $time, want.move, out_ch.move_out);
          end
        end
      end
      if (in_ch.valid && in_ch.ready)
        answer_q.push_back(predict_answer(act_t'(in_ch.action), in_ch.bucket,
                                          in_ch.move_in, in_ch.score_in));
    end
    pending = answer_q.size();
  end

endmodule

// ===== tb/sv/bucketed_top_k_sorted_store_unit_tb.sv =====
`timescale 1ns / 100ps
// Top of the testbench for the bucketed top-K sorted store: clock, reset,
// command stimulus, result back-pressure and the verdict.
// Depends on btk_pkg, btk_if, the store unit and btk_store_checker.
module bucketed_top_k_sorted_store_unit_tb;
  import btk_pkg::*;

  localparam int PHASE_ITEMS = 200;
  localparam int DRAIN       = 20;
  localparam int LIMIT       = 200000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   send_idle = 0;
  int   stall_pct = 0;
  int   cycles = 0;
  int   sent = 0;
  int   fail_count;
  int   pending;

  btk_in_if  in_ch();
  btk_out_if out_ch();

  bucketed_top_k_sorted_store_unit uut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  btk_store_checker chk (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Clock, 8 ns period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Cycle budget; running past it means the block has hung.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Result side back-pressure.
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // One command transfer, with a random gap ahead of it.
  task automatic send_cmd(input act_t a, input logic [7:0] b,
                          input logic [15:0] mv, input logic [15:0] sc);
    while ($urandom_range(0, 99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.action   <= a;
    in_ch.bucket   <= b;
    in_ch.move_in  <= mv;
    in_ch.score_in <= sc;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent++;
  endtask

  // Mostly a few hot buckets so that they fill up and start replacing.
  function automatic logic [7:0] pick_bucket();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 8'($urandom_range(0, 1));
    if (r < 80) return 8'($urandom_range(2, 5));
    return 8'($urandom);
  endfunction

  // Half the scores come from a narrow range to force ties.
  function automatic logic [15:0] pick_score();
    if ($urandom_range(0, 1) == 0) return 16'(int'($urandom_range(0, 15)) - 8);
    return 16'($urandom);
  endfunction

  // Random traffic: insert bursts, rewind-and-scan runs, clears and noise.
  task automatic run_random();
    int k;
    logic [7:0] b;
    sent = 0;
    while (sent < PHASE_ITEMS) begin
      k = $urandom_range(0, 99);
      b = pick_bucket();
      if (k < 45) begin
        repeat ($urandom_range(1, 6))
          send_cmd(ACT_INSERT, b, 16'($urandom), pick_score());
      end else if (k < 80) begin
        send_cmd(ACT_REWIND, 8'($urandom), 16'($urandom), 16'($urandom));
        repeat ($urandom_range(1, KEEP + 1))
          send_cmd(ACT_READ, b, 16'($urandom), 16'($urandom));
      end else if (k < 82) begin
        send_cmd(ACT_CLEAR, 8'($urandom), 16'($urandom), 16'($urandom));
      end else begin
        send_cmd(act_t'($urandom_range(0, 3)), 8'($urandom), 16'($urandom),
                 16'($urandom));
      end
    end
  endtask

  initial begin
    in_ch.valid    <= 1'b0;
    in_ch.action   <= ACT_CLEAR;
    in_ch.bucket   <= 8'd0;
    in_ch.move_in  <= 16'd0;
    in_ch.score_in <= 16'd0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: empty reads, score extremes, ties, a full bucket that
    // rejects an equal score and takes a better one, reading past the end,
    // the highest bucket and the widest move.
    send_cmd(ACT_CLEAR,  8'd0, 16'd0, 16'd0);
    send_cmd(ACT_READ,   8'd0, 16'd0, 16'd0);
    send_cmd(ACT_INSERT, 8'd0, 16'h0001, 16'sd5);
    send_cmd(ACT_INSERT, 8'd0, 16'h0002, 16'sd5);
    send_cmd(ACT_INSERT, 8'd0, 16'h0000, 16'h8000);
    send_cmd(ACT_INSERT, 8'd0, 16'hFFFF, 16'h7FFF);
    send_cmd(ACT_INSERT, 8'd0, 16'h0005, 16'sd0);
    send_cmd(ACT_INSERT, 8'd0, 16'h0006, 16'sd0);
    send_cmd(ACT_INSERT, 8'd0, 16'h0007, 16'sd5);
    send_cmd(ACT_INSERT, 8'd0, 16'h0008, 16'sd100);
    send_cmd(ACT_INSERT, 8'd0, 16'h0009, 16'h7FFF);
    send_cmd(ACT_INSERT, 8'd0, 16'h000A, 16'sd3);
    send_cmd(ACT_REWIND, 8'd0, 16'd0, 16'd0);
    repeat (KEEP + 1) send_cmd(ACT_READ, 8'd0, 16'd0, 16'd0);
    send_cmd(ACT_INSERT, 8'd255, 16'hFFFF, 16'hFFFF);
    send_cmd(ACT_REWIND, 8'd255, 16'hFFFF, 16'hFFFF);
    send_cmd(ACT_READ,   8'd255, 16'hFFFF, 16'hFFFF);
    send_cmd(ACT_READ,   8'd255, 16'd0, 16'd0);
    send_cmd(ACT_CLEAR,  8'd0, 16'd0, 16'd0);
    send_cmd(ACT_READ,   8'd0, 16'd0, 16'd0);

    // Random part over the idling phases.
    run_random();
    send_idle = 54;
    stall_pct = 0;
    run_random();
    send_idle = 0;
    stall_pct = 54;
    run_random();
    send_idle = 32;
    stall_pct = 32;
    run_random();

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
